// ----- hdl/quadratic_positive_root_solver_top_defines.svh -----
// Assertion macros used by the checker file qprs_checker.sv.
`ifndef QUADRATIC_POSITIVE_ROOT_SOLVER_TOP_DEFINES_SVH
`define QUADRATIC_POSITIVE_ROOT_SOLVER_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define QPRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define QPRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/qprs_pkg.sv -----
package qprs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [30:0] THR_RESET = 31'd66;

  localparam int SQ_ITERS = 32;
  localparam int SQ_PER = 2;
  localparam int SQ_STG = SQ_ITERS / SQ_PER;

  localparam int DIV_ITERS = 32;
  localparam int DIV_PER = 2;
  localparam int DIV_STG = DIV_ITERS / DIV_PER;

  typedef struct packed {
    logic               degen;
    logic               ok;
    logic               big;
    logic               ac_pos;
    logic               a_neg;
    logic signed [31:0] b;
    logic [32:0]        den;
    logic               neg1;
    logic               neg2;
    logic               sat1;
    logic               sat2;
  } side_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] fix_root(input logic [31:0] q, input logic neg,
                                           input logic sat);
    if (neg) begin
      fix_root = (sat || q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
    end else begin
      fix_root = (sat || q[31]) ? 32'h7fff_ffff : q;
    end
  endfunction

endpackage

// ----- hdl/quadratic_positive_root_solver_top.sv -----
// Throughput: one request per cycle while the pipeline advances; the square root runs
// two result bits per stage over 16 stages and both divisions run two quotient bits
// per stage over 16.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads the
// discriminant threshold with its default.
module quadratic_positive_root_solver_top #(
  parameter int FRAC_BITS = qprs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_coef_c,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_root_count,
  output logic signed [31:0] out_first_root,
  output logic signed [31:0] out_second_root,
  output logic               out_degenerate
);
  import qprs_pkg::*;

  localparam int DVD_W = 34 + FRAC_BITS;

  logic        en;
  logic [30:0] thr_r;

  logic        v1_r;
  logic [63:0] bb1_r, m1_r;
  side_t       sd1_r, sd1_nxt;

  logic        v2_r;
  logic [65:0] d2_r, d2_nxt;
  side_t       sd2_r, sd2_nxt;

  logic        sq_v_r   [0:SQ_STG];
  logic [63:0] sq_x_r   [0:SQ_STG];
  logic [33:0] sq_rem_r [0:SQ_STG];
  logic [31:0] sq_root_r[0:SQ_STG];
  side_t       sq_sd_r  [0:SQ_STG];
  logic [63:0] x3_nxt;
  side_t       sd3_nxt;

  logic        vn_r;
  logic [34:0] num1_r, num2_r, num1_nxt, num2_nxt;
  side_t       sdn_r;
  logic [32:0] s_c;
  logic [34:0] nb_c;

  logic        dv_v_r   [0:DIV_STG];
  logic [33:0] dv_rem1_r[0:DIV_STG];
  logic [33:0] dv_rem2_r[0:DIV_STG];
  logic [31:0] dv_q1_r  [0:DIV_STG];
  logic [31:0] dv_q2_r  [0:DIV_STG];
  logic [31:0] dv_lo1_r [0:DIV_STG];
  logic [31:0] dv_lo2_r [0:DIV_STG];
  side_t       dv_sd_r  [0:DIV_STG];
  logic [33:0] mag1_c, mag2_c;
  logic [DVD_W-1:0] n1_c, n2_c;
  side_t       sdd_nxt;

  logic        out_valid_r;
  logic [1:0]  cnt_nxt, cnt_r;
  logic [31:0] first_nxt, second_nxt, first_r, second_r;
  logic        degen_r;
  logic [31:0] r1_c, r2_c;
  logic        p1_c, p2_c;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      sq_v_r[0]   <= 1'b0;
      vn_r        <= 1'b0;
      dv_v_r[0]   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      sq_v_r[0]   <= v2_r;
      vn_r        <= sq_v_r[SQ_STG];
      dv_v_r[0]   <= vn_r;
      out_valid_r <= dv_v_r[DIV_STG];
    end
  end

  // Products of magnitudes.
  always_comb begin
    sd1_nxt        = '0;
    sd1_nxt.degen  = (in_coef_a == 32'sd0);
    sd1_nxt.a_neg  = in_coef_a[31];
    sd1_nxt.b      = in_coef_b;
    sd1_nxt.den    = {abs32(in_coef_a), 1'b0};
    sd1_nxt.ac_pos = (in_coef_c != 32'sd0) && (in_coef_a[31] == in_coef_c[31]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb1_r <= abs32(in_coef_b) * abs32(in_coef_b);
      m1_r  <= abs32(in_coef_a) * abs32(in_coef_c);
      sd1_r <= sd1_nxt;
    end
  end

  // Discriminant, exact, with twice the fraction bits.
  always_comb begin
    sd2_nxt = sd1_r;
    if (sd1_r.ac_pos) begin
      sd2_nxt.ok = ({m1_r, 2'b00} <= {2'b00, bb1_r});
      d2_nxt     = {2'b00, bb1_r} - {m1_r, 2'b00};
    end else begin
      sd2_nxt.ok = 1'b1;
      d2_nxt     = {2'b00, bb1_r} + {m1_r, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r  <= d2_nxt;
      sd2_r <= sd2_nxt;
    end
  end

  // Threshold test and square root operand selection.
  always_comb begin
    sd3_nxt     = sd2_r;
    sd3_nxt.big = |d2_r[65:64];
    if (!sd3_nxt.big && (d2_r[63:0] < (64'(thr_r) << FRAC_BITS))) begin
      sd3_nxt.ok = 1'b0;
    end
    x3_nxt = sd3_nxt.big ? d2_r[65:2] : d2_r[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r[0]    <= x3_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_sd_r[0]   <= sd3_nxt;
    end
  end

  for (genvar k = 0; k < SQ_STG; k++) begin : g_sq
    logic [33:0] rem_c;
    logic [31:0] root_c;
    logic [63:0] x_c;
    logic [33:0] trial_c;

    always_comb begin
      rem_c   = sq_rem_r[k];
      root_c  = sq_root_r[k];
      x_c     = sq_x_r[k];
      trial_c = '0;
      for (int j = 0; j < SQ_PER; j++) begin
        rem_c   = {rem_c[31:0], x_c[63:62]};
        trial_c = {root_c, 2'b01};
        if (rem_c >= trial_c) begin
          rem_c  = rem_c - trial_c;
          root_c = {root_c[30:0], 1'b1};
        end else begin
          root_c = {root_c[30:0], 1'b0};
        end
        x_c = {x_c[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x_r[k+1]    <= x_c;
        sq_rem_r[k+1]  <= rem_c;
        sq_root_r[k+1] <= root_c;
        sq_sd_r[k+1]   <= sq_sd_r[k];
      end
    end
  end

  // Numerators -b - s and -b + s.
  always_comb begin
    s_c = sq_sd_r[SQ_STG].big ? {sq_root_r[SQ_STG], 1'b0} : {1'b0, sq_root_r[SQ_STG]};
    nb_c = 35'd0 - {{3{sq_sd_r[SQ_STG].b[31]}}, sq_sd_r[SQ_STG].b};
    num1_nxt = nb_c - {2'b00, s_c};
    num2_nxt = nb_c + {2'b00, s_c};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r <= num1_nxt;
      num2_r <= num2_nxt;
      sdn_r  <= sq_sd_r[SQ_STG];
    end
  end

  // Dividend setup and overflow test against the divisor 2a.
  always_comb begin
    mag1_c = num1_r[34] ? 34'(35'd0 - num1_r) : num1_r[33:0];
    mag2_c = num2_r[34] ? 34'(35'd0 - num2_r) : num2_r[33:0];
    n1_c   = {mag1_c, {FRAC_BITS{1'b0}}};
    n2_c   = {mag2_c, {FRAC_BITS{1'b0}}};
    sdd_nxt      = sdn_r;
    sdd_nxt.neg1 = num1_r[34] != sdn_r.a_neg;
    sdd_nxt.neg2 = num2_r[34] != sdn_r.a_neg;
    sdd_nxt.sat1 = 33'(n1_c[DVD_W-1:32]) >= sdn_r.den;
    sdd_nxt.sat2 = 33'(n2_c[DVD_W-1:32]) >= sdn_r.den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem1_r[0] <= 34'(n1_c[DVD_W-1:32]);
      dv_rem2_r[0] <= 34'(n2_c[DVD_W-1:32]);
      dv_lo1_r[0]  <= n1_c[31:0];
      dv_lo2_r[0]  <= n2_c[31:0];
      dv_q1_r[0]   <= '0;
      dv_q2_r[0]   <= '0;
      dv_sd_r[0]   <= sdd_nxt;
    end
  end

  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    logic [33:0] rem1_c, rem2_c;
    logic [31:0] q1_c, q2_c, lo1_c, lo2_c;
    logic [33:0] d_c;

    always_comb begin
      rem1_c = dv_rem1_r[k];
      rem2_c = dv_rem2_r[k];
      q1_c   = dv_q1_r[k];
      q2_c   = dv_q2_r[k];
      lo1_c  = dv_lo1_r[k];
      lo2_c  = dv_lo2_r[k];
      d_c    = {1'b0, dv_sd_r[k].den};
      for (int j = 0; j < DIV_PER; j++) begin
        rem1_c = {rem1_c[32:0], lo1_c[31]};
        rem2_c = {rem2_c[32:0], lo2_c[31]};
        if (rem1_c >= d_c) begin
          rem1_c = rem1_c - d_c;
          q1_c   = {q1_c[30:0], 1'b1};
        end else begin
          q1_c   = {q1_c[30:0], 1'b0};
        end
        if (rem2_c >= d_c) begin
          rem2_c = rem2_c - d_c;
          q2_c   = {q2_c[30:0], 1'b1};
        end else begin
          q2_c   = {q2_c[30:0], 1'b0};
        end
        lo1_c = {lo1_c[30:0], 1'b0};
        lo2_c = {lo2_c[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem1_r[k+1] <= rem1_c;
        dv_rem2_r[k+1] <= rem2_c;
        dv_q1_r[k+1]   <= q1_c;
        dv_q2_r[k+1]   <= q2_c;
        dv_lo1_r[k+1]  <= lo1_c;
        dv_lo2_r[k+1]  <= lo2_c;
        dv_sd_r[k+1]   <= dv_sd_r[k];
      end
    end
  end

  // Saturation, positivity and ordering of the roots.
  always_comb begin
    r1_c = fix_root(dv_q1_r[DIV_STG], dv_sd_r[DIV_STG].neg1, dv_sd_r[DIV_STG].sat1);
    r2_c = fix_root(dv_q2_r[DIV_STG], dv_sd_r[DIV_STG].neg2, dv_sd_r[DIV_STG].sat2);
    p1_c = !r1_c[31] && (r1_c != 32'd0);
    p2_c = !r2_c[31] && (r2_c != 32'd0);
    cnt_nxt    = 2'd0;
    first_nxt  = '0;
    second_nxt = '0;
    if (dv_sd_r[DIV_STG].ok && !dv_sd_r[DIV_STG].degen) begin
      if (p1_c && p2_c) begin
        cnt_nxt    = 2'd2;
        first_nxt  = r1_c;
        second_nxt = r2_c;
      end else if (p1_c) begin
        cnt_nxt   = 2'd1;
        first_nxt = r1_c;
      end else if (p2_c) begin
        cnt_nxt   = 2'd1;
        first_nxt = r2_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      degen_r  <= dv_sd_r[DIV_STG].degen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_count  = cnt_r;
  assign out_first_root  = first_r;
  assign out_second_root = second_r;
  assign out_degenerate  = degen_r;

endmodule

// ----- hdl/qprs_checker.sv -----
`include "quadratic_positive_root_solver_top_defines.svh"

module qprs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_root_count,
  input logic signed [31:0] out_first_root,
  input logic signed [31:0] out_second_root,
  input logic               out_degenerate
);

  `QPRS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_first_root) && $stable(out_second_root) && $stable(out_root_count), "Stalled result changed.")
  `QPRS_ASSERT(a_count_range, out_valid |-> out_root_count != 2'd3, "Root count out of range.")
  `QPRS_ASSERT(a_degen_none, out_valid && out_degenerate |-> out_root_count == 2'd0, "Degenerate request reports roots.")
  `QPRS_ASSERT(a_unused_zero, out_valid && out_root_count != 2'd2 |-> out_second_root == 32'sd0, "Unused second root is not zero.")
  `QPRS_ASSERT(a_first_pos, out_valid && out_root_count != 2'd0 |-> !out_first_root[31] && out_first_root != 32'sd0, "Reported first root is not positive.")

endmodule

bind quadratic_positive_root_solver_top qprs_checker u_qprs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_root_count  (out_root_count),
  .out_first_root  (out_first_root),
  .out_second_root (out_second_root),
  .out_degenerate  (out_degenerate)
);

// ----- dv/quadratic_positive_root_solver_checker.sv -----
module quadratic_positive_root_solver_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_coef_c,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_root_count,
  input  logic signed [31:0] out_first_root,
  input  logic signed [31:0] out_second_root,
  input  logic               out_degenerate,
  output int                 fail_count,
  output int                 pending_roots,
  output int                 solved_count,
  output int                 two_root_count,
  output int                 one_root_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         count;
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic               degen;
  } roots_t;

  roots_t     expected_roots[$];
  logic [30:0] threshold;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x = x - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] scaled_quotient(input logic signed [65:0] num,
                                                         input logic signed [33:0] den);
    logic        neg;
    logic [65:0] n_mag;
    logic [33:0] d_mag;
    logic [81:0] q;
    neg = (num < 0) != (den < 0);
    n_mag = (num < 0) ? -num : num;
    d_mag = (den < 0) ? -den : den;
    q = {n_mag, 16'b0} / d_mag;
    if (neg) begin
      return (q > 82'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
    end
    return (q > 82'h7fff_ffff) ? 32'sh7fff_ffff : q[31:0];
  endfunction

  function automatic roots_t solve_roots(input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic signed [31:0] c,
                                         input logic [30:0] thr);
    roots_t             r;
    logic signed [63:0] aw, bw, cw;
    logic [63:0]        a_mag, b_mag, c_mag, bb, m, s;
    logic [67:0]        disc;
    logic               ok, ac_pos;
    logic signed [65:0] nb, sw;
    logic signed [33:0] den;
    logic signed [31:0] r1, r2;
    r = '0;
    aw = 64'(a);
    bw = 64'(b);
    cw = 64'(c);
    if (a == 0) begin
      r.degen = 1'b1;
      return r;
    end
    a_mag = (aw < 0) ? -aw : aw;
    b_mag = (bw < 0) ? -bw : bw;
    c_mag = (cw < 0) ? -cw : cw;
    bb = b_mag * b_mag;
    m = a_mag * c_mag;
    ok = 1'b1;
    disc = '0;
    ac_pos = (c != 0) && ((a < 0) == (c < 0));
    if (ac_pos) begin
      if ({m, 2'b0} > {4'b0, bb}) ok = 1'b0;
      else disc = {4'b0, bb} - {2'b0, m, 2'b0};
    end else begin
      disc = {4'b0, bb} + {2'b0, m, 2'b0};
    end
    if (ok && disc[67:64] == 0 && disc < ({37'b0, thr} << 16)) ok = 1'b0;
    if (!ok) return r;
    if (disc[67:64] == 0) s = floor_sqrt(disc[63:0]);
    else s = 2 * floor_sqrt(disc[65:2]);
    nb = 66'(bw);
    nb = -nb;
    sw = $signed({2'b0, s});
    den = 34'(a);
    den = den * 2;
    r1 = scaled_quotient(nb - sw, den);
    r2 = scaled_quotient(nb + sw, den);
    if (r1 > 0 && r2 > 0) begin
      r.count = 2'd2;
      r.first = r1;
      r.second = r2;
    end else if (r1 > 0) begin
      r.count = 2'd1;
      r.first = r1;
    end else if (r2 > 0) begin
      r.count = 2'd1;
      r.first = r2;
    end
    return r;
  endfunction

  assign pending_roots = expected_roots.size();

  initial begin
    fail_count = 0;
    solved_count = 0;
    two_root_count = 0;
    one_root_count = 0;
    threshold = 31'd66;
  end

  always @(posedge clk) begin
    roots_t exp_r;
    if (!rst_n) begin
      threshold <= 31'd66;
    end else begin
      if (cfg_wr_en) threshold <= cfg_wr_data;
      if (in_valid && in_ready) begin
        expected_roots.push_back(solve_roots(in_coef_a, in_coef_b, in_coef_c, threshold));
      end
      if (out_valid && out_ready) begin
        solved_count++;
        if (out_root_count == 2) two_root_count++;
        if (out_root_count == 1) one_root_count++;
        if (expected_roots.size() == 0) begin
          $display("%0t: result with no request waiting: count %0d", $time, out_root_count);
          fail_count++;
        end else begin
          exp_r = expected_roots.pop_front();
          if (out_root_count !== exp_r.count) begin
            $display("%0t: root_count expected %0d actual %0d", $time, exp_r.count,
                     out_root_count);
            fail_count++;
          end
          if (out_first_root !== exp_r.first) begin
            $display("%0t: first_root expected %h actual %h", $time, exp_r.first,
                     out_first_root);
            fail_count++;
          end
          if (out_second_root !== exp_r.second) begin
            $display("%0t: second_root expected %h actual %h", $time, exp_r.second,
                     out_second_root);
            fail_count++;
          end
          if (out_degenerate !== exp_r.degen) begin
            $display("%0t: degenerate expected %0d actual %0d", $time, exp_r.degen,
                     out_degenerate);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ----- dv/quadratic_positive_root_solver_top_tb.sv -----
module quadratic_positive_root_solver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [30:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_coef_a;
  logic signed [31:0] in_coef_b;
  logic signed [31:0] in_coef_c;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_root_count;
  logic signed [31:0] out_first_root;
  logic signed [31:0] out_second_root;
  logic               out_degenerate;
  int                 fail_count;
  int                 pending_roots;
  int                 solved_count;
  int                 two_root_count;
  int                 one_root_count;
  int                 cycle_count;
  int                 sent_count;

  quadratic_positive_root_solver_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_coef_a      (in_coef_a),
    .in_coef_b      (in_coef_b),
    .in_coef_c      (in_coef_c),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_root_count (out_root_count),
    .out_first_root (out_first_root),
    .out_second_root(out_second_root),
    .out_degenerate (out_degenerate)
  );

  quadratic_positive_root_solver_checker u_checker (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    cycle_count = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_coef_c = '0;
    out_ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // The result side alternates between free-running stretches and random stalls.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) < 2) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end else begin
        out_ready <= 1'($urandom_range(0, 1));
        repeat (gap_length() + 1) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input bit no_gap);
    bit taken;
    int gap;
    in_valid <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sent_count++;
    gap = no_gap ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_threshold(input logic [30:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_roots != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_from_roots(input bit no_gap);
    longint a, r1, r2, b, c;
    a = $signed($urandom_range(1, 1 << 20));
    if ($urandom_range(0, 1)) a = -a;
    r1 = $signed($urandom_range(0, 1 << 21)) - (1 << 19);
    r2 = $signed($urandom_range(0, 1 << 21)) - (1 << 19);
    b = -((a * (r1 + r2)) >>> 16);
    c = (((a * r1) >>> 16) * r2) >>> 16;
    send_request(a[31:0], b[31:0], c[31:0], no_gap);
  endtask

  task automatic send_random(input bit no_gap);
    int pick;
    logic [31:0] a, b, c;
    longint aw, bw;
    pick = $urandom_range(0, 99);
    a = $urandom();
    b = $urandom();
    c = $urandom();
    if (pick < 60) begin
      send_from_roots(no_gap);
      return;
    end else if (pick < 70) begin
      aw = $signed($urandom_range(1, 1 << 18));
      bw = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      c = 32'(((bw * bw) / (4 * aw)) + $signed($urandom_range(0, 8)) - 4);
      a = aw[31:0];
      b = bw[31:0];
    end else if (pick < 75) begin
      a = 0;
    end else if (pick < 85) begin
      a = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      b = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      c = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    end
    send_request(a, b, c, no_gap);
  endtask

  initial begin
    logic [30:0] thr_values[5];
    sent_count = 0;
    thr_values[0] = 31'd0;
    thr_values[1] = 31'h7fff_ffff;
    thr_values[2] = 31'd66;
    thr_values[3] = 31'($urandom_range(1, 1 << 20));
    thr_values[4] = 31'($urandom() >> 1);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases under the reset threshold.
    send_request(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 0);
    send_request(32'h0001_0000, 32'hffff_0000, 32'hfffe_0000, 0);
    send_request(32'h0001_0000, 32'h0001_0000, 32'hfffe_0000, 0);
    send_request(32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 0);
    send_request(32'hffff_0000, 32'h0003_0000, 32'hfffe_0000, 0);
    send_request(32'hffff_0000, 32'h0001_0000, 32'h0002_0000, 0);
    send_request(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 0);
    send_request(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 0);
    send_request(32'h0000_0000, 32'h1234_5678, 32'h8000_0000, 0);
    send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
    send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_request(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_request(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0);
    send_request(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_request(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_request(32'h0000_0001, 32'h0000_0000, 32'hffff_ffff, 0);
    send_request(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 0);
    send_request(32'h0001_0000, 32'h0000_0100, 32'h0000_0000, 0);
    send_request(32'h0001_0000, 32'h0000_0000, 32'hffff_ffff, 0);

    for (int phase = 0; phase < 5; phase++) begin
      write_threshold(thr_values[phase]);
      for (int i = 0; i < 186; i++) send_random(phase == 2 && i < 60);
    end

    in_valid <= 1'b0;
    while (pending_roots != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d requests over five threshold settings, reset and both extremes included.",
             sent_count);
    $display("Checked %0d results: %0d with two positive roots, %0d with one.",
             solved_count, two_root_count, one_root_count);
    if (fail_count == 0 && pending_roots == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/qprs_pkg.sv
hdl/quadratic_positive_root_solver_top.sv
hdl/qprs_checker.sv
dv/quadratic_positive_root_solver_checker.sv
dv/quadratic_positive_root_solver_top_tb.sv
